@@ sv/opr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the overlay patch read unit.
package opr_pkg;

    localparam int MAX_REGIONS_DEF  = 16;
    localparam int REGION_BYTES_DEF = 64;

    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_INSTALL    = 3'd1;
    localparam logic [2:0] OP_LOAD       = 3'd2;
    localparam logic [2:0] OP_REMOVE     = 3'd3;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } tbl_cmd_t;

endpackage

@@ sv/opr_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: one operation per transaction.
interface opr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] address;
    logic        clean;
    logic [7:0]  base_byte;
    logic [5:0]  region_len;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;

    modport source (
        output valid, opcode, address, clean, base_byte, region_len, byte_index, byte_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, address, clean, base_byte, region_len, byte_index, byte_value,
        output ready
    );
endinterface

@@ sv/opr_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: one result per transaction.
interface opr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_overlay;
    logic [1:0] status;
    logic [4:0] active_count;

    modport source (
        output valid, data_byte, from_overlay, status, active_count,
        input  ready
    );
    modport sink (
        input  valid, data_byte, from_overlay, status, active_count,
        output ready
    );
endinterface

@@ sv/opr_region_table.sv @@
`timescale 1ns / 1ps
// Region stack registers with parallel coverage compare and newest-wins select.
module opr_region_table #(
    parameter int MAX_REGIONS = opr_pkg::MAX_REGIONS_DEF,
    localparam int CW = $clog2(MAX_REGIONS + 1),
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  opr_pkg::tbl_cmd_t cmd,
    input  logic [31:0]      wr_start,
    input  logic [5:0]       wr_len,
    input  logic [31:0]      lookup_addr,
    output logic [CW-1:0]    count,
    output logic [5:0]       top_len,
    output logic             hit,
    output logic [IW-1:0]    hit_idx,
    output logic [5:0]       hit_off
);

    logic [31:0]   start_reg [MAX_REGIONS];
    logic [5:0]    len_reg   [MAX_REGIONS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] top_idx;
    logic [MAX_REGIONS-1:0] cover_vec;
    logic [5:0]    off_vec [MAX_REGIONS];

    assign count    = count_reg;
    assign count_m1 = count_reg - CW'(1);
    assign wr_idx   = count_reg[IW-1:0];
    assign top_idx  = count_m1[IW-1:0];
    assign top_len  = len_reg[top_idx];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            start_reg[wr_idx] <= wr_start;
            len_reg[wr_idx]   <= wr_len;
        end
    end

    // Coverage is start <= a < start + len at 33 bits, no wrap.
    always_comb
    begin
        logic [32:0] lo;
        logic [32:0] hi;
        logic [31:0] diff;
        for (int k = 0; k < MAX_REGIONS; k++)
        begin
            lo           = {1'b0, start_reg[k]};
            hi           = lo + 33'(len_reg[k]);
            diff         = lookup_addr - start_reg[k];
            off_vec[k]   = diff[5:0];
            cover_vec[k] = (CW'(k) < count_reg) && ({1'b0, lookup_addr} >= lo)
                           && ({1'b0, lookup_addr} < hi);
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        hit_off = '0;
        for (int k = 0; k < MAX_REGIONS; k++)
        begin
            if (cover_vec[k])
            begin
                hit     = 1'b1;
                hit_idx = IW'(k);
                hit_off = off_vec[k];
            end
        end
    end

endmodule

@@ sv/opr_patch_ram.sv @@
`timescale 1ns / 1ps
// Patch byte memory, single port, registered read.
module opr_patch_ram #(
    parameter int DEPTH = opr_pkg::MAX_REGIONS_DEF * opr_pkg::REGION_BYTES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/overlay_patch_read_unit.sv @@
`timescale 1ns / 1ps
// Overlay patch read unit: region stack over a byte space with patch byte memory.
// Request fields are registered on acceptance; in S_LOOK the region compare and the patch
// memory read share the state, and the result registers load at its end. No new request is
// taken while S_LOOK is busy, and a stalled result holds off the next request. Reset clears
// the region count and handshake state; region registers and patch memory hold no reset
// value. Region registers are read only after writes; patch memory is to be read only after
// writes, a rule for the user that the block itself does not enforce.
module overlay_patch_read_unit #(
    parameter int MAX_REGIONS  = opr_pkg::MAX_REGIONS_DEF,
    parameter int REGION_BYTES = opr_pkg::REGION_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    opr_req_if.sink    req,
    opr_rsp_if.source  rsp
);

    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int IW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int DEPTH = MAX_REGIONS * REGION_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } state_t;

    state_t      state_reg;
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [1:0]  out_status_reg;
    logic [4:0]  out_count_reg;
    logic [7:0]  out_base_reg;

    logic [2:0]  op_reg;
    logic [31:0] addr_reg;
    logic        clean_reg;
    logic [7:0]  base_reg;
    logic [5:0]  len_reg;
    logic [5:0]  idx_reg;
    logic [7:0]  val_reg;

    logic        accept;
    opr_pkg::tbl_cmd_t cmd;
    logic [CW-1:0] count;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_after;
    logic [5:0]    top_len;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [5:0]    hit_off;
    logic [1:0]    status;
    logic          use_hit;
    logic          ram_en;
    logic          ram_we;
    logic [IW-1:0] row;
    logic [5:0]    col;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign count_m1  = count - CW'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.opcode;
            addr_reg  <= req.address;
            clean_reg <= req.clean;
            base_reg  <= req.base_byte;
            len_reg   <= req.region_len;
            idx_reg   <= req.byte_index;
            val_reg   <= req.byte_value;
        end
    end

    opr_region_table #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .wr_start    (addr_reg),
        .wr_len      (len_reg),
        .lookup_addr (addr_reg),
        .count       (count),
        .top_len     (top_len),
        .hit         (hit),
        .hit_idx     (hit_idx),
        .hit_off     (hit_off)
    );

    always_comb
    begin
        cmd         = '0;
        status      = opr_pkg::ST_OK;
        use_hit     = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        row         = hit_idx;
        col         = hit_off;
        count_after = count;
        if (state_reg == S_LOOK)
        begin
            case (op_reg)
                opr_pkg::OP_READ:
                begin
                    if (!clean_reg && hit)
                    begin
                        use_hit = 1'b1;
                        ram_en  = 1'b1;
                    end
                end
                opr_pkg::OP_INSTALL:
                begin
                    if (count >= CW'(MAX_REGIONS))
                    begin
                        status = opr_pkg::ST_FULL;
                    end
                    else if (32'(len_reg) >= 32'(REGION_BYTES))
                    begin
                        status = opr_pkg::ST_LONG;
                    end
                    else
                    begin
                        cmd.push    = 1'b1;
                        count_after = count + CW'(1);
                    end
                end
                opr_pkg::OP_LOAD:
                begin
                    if (count == '0 || idx_reg >= top_len)
                    begin
                        status = opr_pkg::ST_BAD;
                    end
                    else
                    begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                        row    = count_m1[IW-1:0];
                        col    = idx_reg;
                    end
                end
                opr_pkg::OP_REMOVE:
                begin
                    if (count == '0)
                    begin
                        status = opr_pkg::ST_BAD;
                    end
                    else
                    begin
                        cmd.pop     = 1'b1;
                        count_after = count_m1;
                    end
                end
                opr_pkg::OP_REMOVE_ALL:
                begin
                    cmd.clear   = 1'b1;
                    count_after = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ram_addr = AW'(row) * AW'(REGION_BYTES) + AW'(col);

    opr_patch_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_status_reg <= opr_pkg::ST_OK;
            out_count_reg  <= '0;
            out_base_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg      <= S_IDLE;
                    out_valid_reg  <= 1'b1;
                    out_hit_reg    <= use_hit;
                    out_status_reg <= status;
                    out_count_reg  <= 5'(count_after);
                    out_base_reg   <= (op_reg == opr_pkg::OP_READ) ? base_reg : 8'd0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.data_byte    = out_hit_reg ? ram_rdata : out_base_reg;
    assign rsp.from_overlay = out_hit_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.active_count = out_count_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!rsp.valid || rsp.ready))
        else $error("request taken while a result is still pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 rsp.valid)
        else $error("result not produced two cycles after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(MAX_REGIONS))
        else $error("region count above table size");

    a_ram_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        ram_en |-> (state_reg == S_LOOK))
        else $error("patch memory accessed outside lookup cycle");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count == $past(count) + CW'(1)))
        else $error("install did not advance region count");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the overlay patch read unit: region stack, patch loads and reads.
module tb_top;

    localparam int NREG         = opr_pkg::MAX_REGIONS_DEF;
    localparam int NBYTES       = opr_pkg::REGION_BYTES_DEF;
    localparam int PLAN         = 0;
    localparam int PRED         = 1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic        hold;
        logic [2:0]  opcode;
        logic [31:0] address;
        logic        clean;
        logic [7:0]  base_byte;
        logic [5:0]  region_len;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
    } opr_op_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       from_overlay;
        logic [1:0] status;
        logic [4:0] active_count;
    } opr_result_t;

    logic clk = 1'b0;
    logic rst_n;

    opr_req_if req ();
    opr_rsp_if rsp ();

    overlay_patch_read_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Two copies of the region stack: PLAN runs ahead at generation, PRED at acceptance.
    int          ov_count  [2];
    logic [31:0] ov_start  [2][NREG];
    logic [5:0]  ov_len    [2][NREG];
    logic [7:0]  ov_patch  [2][NREG*NBYTES];
    logic [NBYTES-1:0] ov_loaded [2][NREG];

    opr_op_t     op_backlog [$];
    opr_result_t overlay_result_q [$];

    int   fail_count = 0;
    int   real_ops   = 0;
    int   total_ops  = 0;
    int   rsp_count;
    int   req_count;
    logic hold_pending = 1'b0;

    int n_hits = 0;
    int n_full = 0;
    int n_bad  = 0;

    function automatic int covering_region(input int s, input logic [31:0] addr);
        logic [32:0] hi;
        int k;
        for (k = ov_count[s] - 1; k >= 0; k--)
        begin
            hi = {1'b0, ov_start[s][k]} + 33'(ov_len[s][k]);
            if (addr >= ov_start[s][k] && {1'b0, addr} < hi)
                return k;
        end
        return -1;
    endfunction

    function automatic opr_result_t apply_overlay_op(input int s, input opr_op_t op);
        opr_result_t res;
        int slot;
        int top;
        logic [31:0] off;
        res = '0;
        case (op.opcode)
            opr_pkg::OP_READ:
            begin
                res.data_byte = op.base_byte;
                if (!op.clean)
                begin
                    slot = covering_region(s, op.address);
                    if (slot >= 0)
                    begin
                        off = op.address - ov_start[s][slot];
                        res.data_byte = ov_patch[s][slot*NBYTES + int'(off)];
                        res.from_overlay = 1'b1;
                    end
                end
            end
            opr_pkg::OP_INSTALL:
            begin
                if (ov_count[s] >= NREG)
                    res.status = opr_pkg::ST_FULL;
                else if (int'(op.region_len) >= NBYTES)
                    res.status = opr_pkg::ST_LONG;
                else
                begin
                    ov_start[s][ov_count[s]]  = op.address;
                    ov_len[s][ov_count[s]]    = op.region_len;
                    ov_loaded[s][ov_count[s]] = '0;
                    ov_count[s]++;
                end
            end
            opr_pkg::OP_LOAD:
            begin
                if (ov_count[s] == 0)
                    res.status = opr_pkg::ST_BAD;
                else
                begin
                    top = ov_count[s] - 1;
                    if (op.byte_index >= ov_len[s][top])
                        res.status = opr_pkg::ST_BAD;
                    else
                    begin
                        ov_patch[s][top*NBYTES + int'(op.byte_index)] = op.byte_value;
                        ov_loaded[s][top][op.byte_index] = 1'b1;
                    end
                end
            end
            opr_pkg::OP_REMOVE:
            begin
                if (ov_count[s] == 0)
                    res.status = opr_pkg::ST_BAD;
                else
                    ov_count[s]--;
            end
            opr_pkg::OP_REMOVE_ALL:
                ov_count[s] = 0;
            default: ;
        endcase
        res.active_count = 5'(ov_count[s]);
        return res;
    endfunction

    // A read that would land on a patch byte not loaded since install is turned into a clean read.
    task automatic queue_op(input logic [2:0] opc, input logic [31:0] addr, input logic cln,
                            input logic [7:0] base, input logic [5:0] len,
                            input logic [5:0] idx, input logic [7:0] val);
        opr_op_t op;
        opr_result_t plan_res;
        int slot;
        op.hold       = hold_pending;
        op.opcode     = opc;
        op.address    = addr;
        op.clean      = cln;
        op.base_byte  = base;
        op.region_len = len;
        op.byte_index = idx;
        op.byte_value = val;
        hold_pending  = 1'b0;
        if (opc == opr_pkg::OP_READ && !cln)
        begin
            slot = covering_region(PLAN, addr);
            if (slot >= 0 && !ov_loaded[PLAN][slot][addr - ov_start[PLAN][slot]])
                op.clean = 1'b1;
        end
        plan_res = apply_overlay_op(PLAN, op);
        op_backlog.push_back(op);
        if (opc <= opr_pkg::OP_REMOVE_ALL)
            real_ops++;
    endtask

    // Request side: bursts with random gaps.
    opr_op_t on_bus;
    logic    drv_took;
    int      burst_left;
    int      gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.opcode     <= '0;
            req.address    <= '0;
            req.clean      <= 1'b0;
            req.base_byte  <= '0;
            req.region_len <= '0;
            req.byte_index <= '0;
            req.byte_value <= '0;
            burst_left = 8;
            gap_left   = 0;
            req_count  = 0;
        end
        else
        begin
            drv_took = req.valid && req.ready;
            if (drv_took)
            begin
                overlay_result_q.push_back(apply_overlay_op(PRED, on_bus));
                req_count++;
            end
            if (!req.valid || drv_took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (op_backlog.size() != 0 &&
                         (!op_backlog[0].hold || req_count == rsp_count))
                begin
                    on_bus = op_backlog.pop_front();
                    req.valid      <= 1'b1;
                    req.opcode     <= on_bus.opcode;
                    req.address    <= on_bus.address;
                    req.clean      <= on_bus.clean;
                    req.base_byte  <= on_bus.base_byte;
                    req.region_len <= on_bus.region_len;
                    req.byte_index <= on_bus.byte_index;
                    req.byte_value <= on_bus.byte_value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 6);
                    end
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Response side: check against the oldest prediction; ready follows its own stall modes.
    opr_result_t want;
    int stall_mode;
    int mode_left;
    int mode_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_count <= 0;
            stall_mode = 0;
            mode_left  = 50;
            mode_cycle = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (overlay_result_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = overlay_result_q.pop_front();
                    if (rsp.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte, rsp.data_byte);
                        fail_count++;
                    end
                    if (rsp.from_overlay !== want.from_overlay)
                    begin
                        $error("from_overlay: expected %0b, got %0b",
                               want.from_overlay, rsp.from_overlay);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.active_count !== want.active_count)
                    begin
                        $error("active_count: expected %0d, got %0d",
                               want.active_count, rsp.active_count);
                        fail_count++;
                    end
                    if (want.from_overlay)
                        n_hits++;
                    if (want.status == opr_pkg::ST_FULL)
                        n_full++;
                    if (want.status == opr_pkg::ST_BAD)
                        n_bad++;
                end
                rsp_count <= rsp_count + 1;
            end
            mode_left--;
            mode_cycle++;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 300);
                mode_cycle = 0;
            end
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(0, 1));
                2: rsp.ready <= ($urandom_range(0, 4) == 0);
                default: rsp.ready <= ((mode_cycle % 7) < 3);
            endcase
        end
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("overlay_patch_read_unit regression: fail");
                $finish;
            end
        end
    end

    int          phase_left;
    int          pick;
    int          k;
    int          i;
    int          w_install;
    int          w_remove;
    int          w_clear;
    int          count_before;
    logic        grow;
    logic [31:0] hood;
    logic [31:0] addr;
    logic [5:0]  len;

    initial
    begin
        rst_n          = 1'b0;
        ov_count[PLAN] = 0;
        ov_count[PRED] = 0;

        // directed: empty stack, zero length, top of address space, overlap, unused opcodes
        queue_op(opr_pkg::OP_READ,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFFF, 1'b1, 8'hFF, 6'd63, 6'd63, 8'hFF);
        queue_op(opr_pkg::OP_REMOVE,  32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h77);
        queue_op(opr_pkg::OP_INSTALL, 32'h0000_0100, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h12);
        queue_op(opr_pkg::OP_READ,    32'h0000_0100, 1'b0, 8'h5A, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_INSTALL, 32'hFFFF_FFF0, 1'b0, 8'h00, 6'd63, 6'd0,  8'h00);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd15, 8'hA5);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h3C);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd63, 8'hEE);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFFF, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFF0, 1'b1, 8'h81, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_READ,    32'h0000_000E, 1'b0, 8'h11, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_INSTALL, 32'hFFFF_FFF8, 1'b0, 8'h00, 6'd8,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd7,  8'hC3);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFFF, 1'b0, 8'h22, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFF0, 1'b0, 8'h33, 6'd0,  6'd0,  8'h00);
        queue_op(3'd5,                32'h1234_5678, 1'b1, 8'hAA, 6'd21, 6'd42, 8'h55);
        queue_op(3'd7,                32'hFFFF_FFFF, 1'b1, 8'hFF, 6'd63, 6'd63, 8'hFF);
        queue_op(opr_pkg::OP_REMOVE,  32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_READ,    32'hFFFF_FFFF, 1'b0, 8'h44, 6'd0,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_REMOVE_ALL, 32'h0000_0000, 1'b0, 8'h00, 6'd0, 6'd0, 8'h00);
        queue_op(opr_pkg::OP_INSTALL, 32'h0000_0000, 1'b0, 8'h00, 6'd1,  6'd0,  8'h00);
        queue_op(opr_pkg::OP_LOAD,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'hFF);
        queue_op(opr_pkg::OP_READ,    32'h0000_0000, 1'b0, 8'h00, 6'd0,  6'd0,  8'h00);

        // random: phases around an address neighborhood, some building the stack to full
        hold_pending = 1'b1;
        phase_left = 0;
        while (real_ops < RANDOM_ITEMS + 26)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 200);
                grow = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 3))
                    0: hood = $urandom();
                    1: hood = 32'hFFFF_FFFF - $urandom_range(0, 200);
                    2: hood = $urandom_range(0, 200);
                    default: hood = $urandom() & 32'hFFFF_F000;
                endcase
                if ($urandom_range(0, 3) == 0)
                    hold_pending = 1'b1;
            end
            phase_left--;
            w_install = grow ? 22 : 12;
            w_remove  = grow ? 2 : 10;
            w_clear   = grow ? 0 : 3;
            pick = $urandom_range(0, 99);
            if (pick < w_install)
            begin
                len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 12));
                count_before = ov_count[PLAN];
                queue_op(opr_pkg::OP_INSTALL, hood + $urandom_range(0, 96), $urandom(),
                         $urandom(), len, $urandom(), $urandom());
                if (ov_count[PLAN] > count_before)
                begin
                    for (i = 0; i < int'(len); i++)
                        if ($urandom_range(0, 3) != 0)
                            queue_op(opr_pkg::OP_LOAD, $urandom(), $urandom(), $urandom(),
                                     $urandom(), i, $urandom());
                end
            end
            else if (pick < w_install + 40)
            begin
                if (ov_count[PLAN] > 0 && $urandom_range(0, 9) < 7)
                begin
                    k = $urandom_range(0, ov_count[PLAN] - 1);
                    addr = ov_start[PLAN][k] + $urandom_range(0, ov_len[PLAN][k]);
                    if ($urandom_range(0, 7) == 0)
                        addr = ov_start[PLAN][k] - 1;
                end
                else if ($urandom_range(0, 2) != 0)
                    addr = hood + $urandom_range(0, 160);
                else
                    addr = $urandom();
                queue_op(opr_pkg::OP_READ, addr, ($urandom_range(0, 4) == 0), $urandom(),
                         $urandom(), $urandom(), $urandom());
            end
            else if (pick < w_install + 48)
                queue_op(opr_pkg::OP_LOAD, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
            else if (pick < w_install + 48 + w_remove)
                queue_op(opr_pkg::OP_REMOVE, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
            else if (pick < w_install + 48 + w_remove + w_clear)
                queue_op(opr_pkg::OP_REMOVE_ALL, $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
            else if (pick < w_install + 51 + w_remove + w_clear)
                queue_op(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
            else if (pick < w_install + 54 + w_remove + w_clear)
                queue_op(opr_pkg::OP_INSTALL, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
            else
                queue_op(opr_pkg::OP_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
        end
        total_ops = op_backlog.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rsp_count != total_ops)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (overlay_result_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", overlay_result_q.size());
            fail_count++;
        end

        $display("checked %0d transactions (%0d table operations), %0d reads hit overlays",
                 rsp_count, real_ops, n_hits);
        $display("rejects seen: %0d full-table installs, %0d empty-stack or bad-index operations",
                 n_full, n_bad);
        if (fail_count == 0)
            $display("overlay_patch_read_unit regression: pass");
        else
            $display("overlay_patch_read_unit regression: fail");
        $finish;
    end

endmodule
